>>> hdl/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; imported by every module of the decoder.
package tgarle_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned WIDE_W  = PIX_W + 1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_COMPRESSED_MODE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PIXEL_TOTAL     = 2'd2;

  // Configuration reset values
  localparam logic             RST_COMPRESSED_MODE = 1'b1;
  localparam logic [BPP_W-1:0] RST_BYTES_PER_PIXEL = 3'd4;
  localparam logic [PIX_W-1:0] RST_PIXEL_TOTAL     = 32'd1;

  localparam logic [BPP_W-1:0] BPP_24 = 3'd3;

  typedef struct packed {
    logic             compressed_mode;
    logic [BPP_W-1:0] bytes_per_pixel;
    logic [PIX_W-1:0] pixel_total;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

endpackage

>>> hdl/tgarle_cfg_regs.sv
// Configuration register file of the TGA run-length pixel decoder.
// Depends on tgarle_pkg.
module tgarle_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tgarle_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tgarle_pkg::PIX_W-1:0]  cfg_wdata,
  output tgarle_pkg::cfg_t              cfg
);
  import tgarle_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compressed_mode <= RST_COMPRESSED_MODE;
      cfg_r.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
      cfg_r.pixel_total     <= RST_PIXEL_TOTAL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMPRESSED_MODE: cfg_r.compressed_mode <= cfg_wdata[0];
        CFG_BYTES_PER_PIXEL: cfg_r.bytes_per_pixel <= cfg_wdata[BPP_W-1:0];
        CFG_PIXEL_TOTAL:     cfg_r.pixel_total     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/tgarle_in_stage.sv
// Input register stage: holds one accepted byte until the core takes it.
// Depends on tgarle_pkg.
module tgarle_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tgarle_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                          take,
  output tgarle_pkg::item_t             item
);
  import tgarle_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_data_byte;
    end
  end

  assign item.valid     = valid_r;
  assign item.data_byte = byte_r;

endmodule

>>> hdl/tgarle_core.sv
// Decode core: packet/pixel state update and the result register.
// Depends on tgarle_pkg.
module tgarle_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tgarle_pkg::cfg_t             cfg,
  input  tgarle_pkg::item_t            item,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tgarle_pkg::PIX_W-1:0] out_pixel_value,
  output logic [tgarle_pkg::CNT_W-1:0] out_repeat_count,
  output logic [tgarle_pkg::PIX_W-1:0] out_first_index,
  output logic                         out_image_done,
  output logic                         out_packet_truncated
);
  import tgarle_pkg::*;

  // decoder state
  logic             expect_header_r, expect_header_nxt;
  logic             packet_is_run_r, packet_is_run_nxt;
  logic [CNT_W-1:0] packet_left_r, packet_left_nxt;
  logic [1:0]       byte_in_pixel_r, byte_in_pixel_nxt;
  logic [PIX_W-1:0] pixel_gather_r, pixel_gather_nxt;
  logic [PIX_W-1:0] pixels_done_r, pixels_done_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pixel_value_r;
  logic [CNT_W-1:0] out_repeat_count_r;
  logic [PIX_W-1:0] out_first_index_r;
  logic             out_image_done_r;
  logic             out_packet_truncated_r;

  logic              is_header, size4, last_byte, emit;
  logic [PIX_W-1:0]  gather_new;
  logic [WIDE_W-1:0] total, done_w, remaining, span_w, rep_raw_w, rep_w;
  logic [CNT_W-1:0]  n, span, rep, hdr_count;
  logic              run, trunc, done;

  assign take = item.valid && (!out_valid_r || !out_stall);

  always_comb begin
    is_header  = cfg.compressed_mode && expect_header_r;
    size4      = (cfg.bytes_per_pixel != BPP_24);
    last_byte  = (byte_in_pixel_r == 2'd3) || (!size4 && (byte_in_pixel_r == 2'd2));
    hdr_count  = item.data_byte[BYTE_W-1] ? (item.data_byte - 8'd127)
                                          : (item.data_byte + 8'd1);
    gather_new = ((byte_in_pixel_r == 2'd0) ? '0 : pixel_gather_r)
               | (PIX_W'(item.data_byte) << {byte_in_pixel_r, 3'b000});

    total     = (cfg.pixel_total == '0) ? {1'b1, {PIX_W{1'b0}}}
                                        : {1'b0, cfg.pixel_total};
    done_w    = {1'b0, pixels_done_r};
    remaining = (done_w < total) ? (total - done_w) : WIDE_W'(1);
    n         = (packet_left_r == '0) ? CNT_W'(1) : packet_left_r;
    run       = cfg.compressed_mode && packet_is_run_r;
    span      = cfg.compressed_mode ? n : CNT_W'(1);
    span_w    = WIDE_W'(span);
    rep_raw_w = run ? span_w : WIDE_W'(1);
    rep_w     = (rep_raw_w > remaining) ? remaining : rep_raw_w;
    rep       = rep_w[CNT_W-1:0];
    trunc     = span_w > remaining;
    done      = rep_w >= remaining;
  end

  always_comb begin
    expect_header_nxt = expect_header_r;
    packet_is_run_nxt = packet_is_run_r;
    packet_left_nxt   = packet_left_r;
    byte_in_pixel_nxt = byte_in_pixel_r;
    pixel_gather_nxt  = pixel_gather_r;
    pixels_done_nxt   = pixels_done_r;
    emit              = 1'b0;
    if (take) begin
      if (is_header) begin
        packet_is_run_nxt = item.data_byte[BYTE_W-1];
        packet_left_nxt   = hdr_count;
        expect_header_nxt = 1'b0;
        byte_in_pixel_nxt = 2'd0;
      end else begin
        pixel_gather_nxt = gather_new;
        if (!last_byte) begin
          byte_in_pixel_nxt = byte_in_pixel_r + 2'd1;
        end else begin
          byte_in_pixel_nxt = 2'd0;
          emit              = 1'b1;
          if (done) begin
            pixels_done_nxt   = '0;
            expect_header_nxt = 1'b1;
            packet_is_run_nxt = 1'b0;
            packet_left_nxt   = '0;
          end else begin
            pixels_done_nxt = pixels_done_r + PIX_W'(rep);
            if (cfg.compressed_mode) begin
              packet_left_nxt = run ? '0 : (n - CNT_W'(1));
              if (run || (n == CNT_W'(1))) begin
                expect_header_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      packet_is_run_r <= 1'b0;
      packet_left_r   <= '0;
      byte_in_pixel_r <= '0;
      pixel_gather_r  <= '0;
      pixels_done_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      expect_header_r <= expect_header_nxt;
      packet_is_run_r <= packet_is_run_nxt;
      packet_left_r   <= packet_left_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      pixel_gather_r  <= pixel_gather_nxt;
      pixels_done_r   <= pixels_done_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_value_r      <= gather_new;
      out_repeat_count_r     <= rep;
      out_first_index_r      <= pixels_done_r;
      out_image_done_r       <= done;
      out_packet_truncated_r <= trunc;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pixel_value      = out_pixel_value_r;
  assign out_repeat_count     = out_repeat_count_r;
  assign out_first_index      = out_first_index_r;
  assign out_image_done       = out_image_done_r;
  assign out_packet_truncated = out_packet_truncated_r;

endmodule

>>> hdl/tga_rle_pixel_decoder.sv
// TGA pixel-data decoder, plain or run-length, 24- or 32-bit pixels. One byte
// is accepted every cycle, stalls aside; a byte sits in the input register
// until the core takes it, and its result, if any, is loaded into the result
// register as the byte is taken and can transfer out from that register.
// Header bytes and all but the last byte of a pixel give no result.
// The core updates its packet and pixel state as each byte is taken; in_stall
// rises only while a result is held by out_stall.
// Top level; depends on tgarle_pkg, tgarle_cfg_regs, tgarle_in_stage, tgarle_core.
module tga_rle_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tgarle_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tgarle_pkg::PIX_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tgarle_pkg::BYTE_W-1:0] in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tgarle_pkg::PIX_W-1:0]  out_pixel_value,
  output logic [tgarle_pkg::CNT_W-1:0]  out_repeat_count,
  output logic [tgarle_pkg::PIX_W-1:0]  out_first_index,
  output logic                          out_image_done,
  output logic                          out_packet_truncated
);
  import tgarle_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  take;

  tgarle_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tgarle_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .take         (take),
    .item         (item)
  );

  tgarle_core u_core (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .item                 (item),
    .take                 (take),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pixel_value      (out_pixel_value),
    .out_repeat_count     (out_repeat_count),
    .out_first_index      (out_first_index),
    .out_image_done       (out_image_done),
    .out_packet_truncated (out_packet_truncated)
  );

endmodule

>>> hdl/tgarle_checker.sv
// Port-level assertions for tga_rle_pixel_decoder, attached by bind.
// Depends on tgarle_pkg.
module tgarle_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tgarle_pkg::PIX_W-1:0]  out_pixel_value,
  input logic [tgarle_pkg::CNT_W-1:0]  out_repeat_count,
  input logic [tgarle_pkg::PIX_W-1:0]  out_first_index,
  input logic                          out_image_done,
  input logic                          out_packet_truncated
);
  import tgarle_pkg::*;

  logic [PIX_W-1:0] exp_index_r, exp_index_nxt;

  // next first index: restart at zero after an image completes
  assign exp_index_nxt = out_image_done ? '0 : (out_first_index + PIX_W'(out_repeat_count));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_index_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_index_r <= exp_index_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_value)
      && $stable(out_repeat_count) && $stable(out_first_index)
      && $stable(out_image_done) && $stable(out_packet_truncated))
    else $error("result changed while stalled");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_repeat_count != '0)
    else $error("zero repeat count");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_first_index == exp_index_r)
    else $error("first index out of sequence");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_pixel_value      (out_pixel_value),
  .out_repeat_count     (out_repeat_count),
  .out_first_index      (out_first_index),
  .out_image_done       (out_image_done),
  .out_packet_truncated (out_packet_truncated)
);
